// File: rtl/core/dtpa_pkg.sv
// Shared types and constants for the direct torque pair allocator.
package dtpa_pkg;

  localparam int unsigned MaxThrusters = 16;
  localparam int unsigned IdxW = $clog2(MaxThrusters);

  typedef enum logic [1:0] {
    OpLoad    = 2'd0,
    OpBuild   = 2'd1,
    OpCommand = 2'd2,
    OpNone    = 2'd3
  } op_e;

  typedef enum logic [0:0] {
    RegTolerance = 1'b0,
    RegCount     = 1'b1
  } reg_e;

  typedef enum logic [3:0] {
    StIdle,
    StBuild,
    StBuildOut,
    StClear,
    StAxis,
    StDiv,
    StAdd1,
    StAdd2,
    StResid,
    StResidEnd,
    StSquare,
    StOut,
    StFail
  } state_e;

  typedef struct packed {
    logic            valid;
    logic [IdxW-1:0] first;
    logic [IdxW-1:0] second;
    logic [31:0]     gain;
  } pair_t;

endpackage

// File: rtl/core/dtpa_divider.sv
// Restoring divider, one quotient bit per cycle: (num << 16) / den, 64-bit quotient.
module dtpa_divider import dtpa_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [31:0] num_i,
  input  logic [31:0] den_i,
  output logic        done_o,
  output logic [63:0] quot_o
);

  logic [63:0] dvd_q, dvd_d;
  logic [32:0] rem_q, rem_d;
  logic [31:0] den_q, den_d;
  logic [6:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d;
  logic [33:0] trial;

  // One shift and trial subtract per cycle.
  always_comb begin
    dvd_d  = dvd_q;
    rem_d  = rem_q;
    den_d  = den_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_o = 1'b0;
    trial  = {rem_q, dvd_q[63]} - {2'b0, den_q};
    if (start_i) begin
      dvd_d  = {16'd0, num_i, 16'd0};
      rem_d  = '0;
      den_d  = den_i;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (!trial[33]) begin
        rem_d = trial[32:0];
        dvd_d = {dvd_q[62:0], 1'b1};
      end else begin
        rem_d = {rem_q[31:0], dvd_q[63]};
        dvd_d = {dvd_q[62:0], 1'b0};
      end
      cnt_d = cnt_q + 7'd1;
      if (cnt_q == 7'd63) begin
        busy_d = 1'b0;
        done_o = 1'b1;
      end
    end
  end

  assign quot_o = dvd_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    rem_q <= rem_d;
    den_q <= den_d;
  end

endmodule

// File: rtl/core/direct_torque_pair_allocator_core.sv
// Top level of the direct torque pair allocator.
// Input items arrive on in_valid_i/in_stall_o, results leave on out_valid_o/
// out_stall_i; a transfer happens when valid is high and stall is low.
// A load item (op 0) writes one matrix column and gives no result.
// A build item (op 1) walks the N columns once per axis and sign, one column
// per cycle, and then gives one status result.
// A command item (op 2) clears the force accumulators, divides each
// non-skipped axis torque by its pair gain in a bit-serial divider and adds
// the quotient to the two accumulators of the pair, computes the residual
// with one shared multiplier, squares the three residuals and the tolerance,
// and gives N results, one per cycle when the receiver does not stall.
// The block takes no new item until the last result of the current one has
// been transferred; a stall simply holds the current result.
// Reset clears the pair map, the ready flag and the accumulators and restores
// tolerance 66 and thruster count 16. Matrix entries hold no value until loaded.
// Configuration is to be written via the APB-style port while idle (unchecked).
module direct_torque_pair_allocator_core import dtpa_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  op_i,
  input  logic [3:0]  column_index_i,
  input  logic signed [23:0] column_torque_x_i,
  input  logic signed [23:0] column_torque_y_i,
  input  logic signed [23:0] column_torque_z_i,
  input  logic signed [31:0] torque_x_i,
  input  logic signed [31:0] torque_y_i,
  input  logic signed [31:0] torque_z_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [3:0]  thruster_number_o,
  output logic [31:0] thruster_force_o,
  output logic        ok_o,
  output logic        map_ready_o,
  output logic        last_o
);

  // Configuration registers.
  logic [31:0] tol_q;
  logic [4:0]  cnt_q;
  logic        cfg_wr;
  reg_e        reg_sel;
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign reg_sel = reg_e'(paddr[2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tol_q <= 32'd66;
      cnt_q <= 5'd16;
    end else if (cfg_wr && paddr[1:0] == 2'b00) begin
      unique case (reg_sel)
        RegTolerance: tol_q <= pwdata;
        RegCount:     cnt_q <= pwdata[4:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      RegTolerance: prdata = tol_q;
      RegCount:     prdata = {27'd0, cnt_q};
      default:      prdata = '0;
    endcase
  end

  // Columns in use, saturated to [2, MaxThrusters].
  logic [4:0] ncols;
  always_comb begin
    priority if (cnt_q < 5'd2) ncols = 5'd2;
    else if (cnt_q > 5'(MaxThrusters)) ncols = 5'(MaxThrusters);
    else ncols = cnt_q;
  end

  // Matrix store: one memory per axis, registered read.
  logic signed [23:0] mem_x [MaxThrusters];
  logic signed [23:0] mem_y [MaxThrusters];
  logic signed [23:0] mem_z [MaxThrusters];
  logic [IdxW-1:0]    rd_addr;
  logic [1:0]         rd_axis;
  logic signed [23:0] rd_data_q;
  logic               load_we;

  always_ff @(posedge clk_i) begin
    if (load_we) begin
      mem_x[column_index_i] <= column_torque_x_i;
      mem_y[column_index_i] <= column_torque_y_i;
      mem_z[column_index_i] <= column_torque_z_i;
    end
    unique case (rd_axis)
      2'd0:    rd_data_q <= mem_x[rd_addr];
      2'd1:    rd_data_q <= mem_y[rd_addr];
      default: rd_data_q <= mem_z[rd_addr];
    endcase
  end

  // Sequencer state.
  state_e state_q, state_d;
  logic [2:0]  pk_q, pk_d;         // pair being built, or axis in command
  logic [4:0]  ix_q, ix_d;         // column walk counter
  logic        rv_q, rv_d;         // read data valid, in the cycle after the read is issued
  logic [IdxW-1:0] rix_q, rix_d;   // column of the data now read
  logic [31:0] m1_q, m1_d, m2_q, m2_d;
  logic [IdxW-1:0] b1_q, b1_d, b2_q, b2_d;
  logic [1:0]  pc_q, pc_d;         // sign match count, saturating at 2
  pair_t       pairs_q [6];
  pair_t       pair_wr;
  logic        pair_we;
  logic        ready_q, ready_d;
  logic [31:0] acc_q [MaxThrusters];
  logic [31:0] acc_wdata;
  logic [IdxW-1:0] acc_waddr;
  logic        acc_we;
  logic signed [31:0] tau_q [3];
  logic [63:0] u_q, u_d;
  logic signed [71:0] eff_q, eff_d;
  logic [63:0] sum_q, sum_d;
  logic [31:0] dm_q [3];
  logic [31:0] dm_wdata;
  logic        dm_we;
  logic        okf_q, okf_d;
  logic [4:0]  oi_q, oi_d;
  logic        div_start, div_done;
  logic [63:0] div_quot;

  // Current axis torque and its magnitude.
  logic signed [31:0] tau_cur;
  logic [31:0] tau_mag;
  logic [2:0]  pidx;
  pair_t       pcur;
  assign tau_cur = tau_q[pk_q[1:0]];
  assign tau_mag = tau_cur[31] ? 32'(-{1'b0, tau_cur}) : tau_cur;
  assign pidx    = {pk_q[1:0], 1'b0} + {2'b0, ~(tau_cur > 0)};
  assign pcur    = pairs_q[pidx];

  dtpa_divider u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (tau_mag),
    .den_i   (pcur.gain),
    .done_o  (div_done),
    .quot_o  (div_quot)
  );

  // Candidate magnitude of the read entry for the pair being built.
  logic        cand;
  logic [31:0] cmag;
  always_comb begin
    if (!pk_q[0]) begin
      cand = rd_data_q > 0;
      cmag = 32'(rd_data_q);
    end else begin
      cand = rd_data_q < 0;
      cmag = 32'(-33'(rd_data_q));
    end
  end

  // Saturating accumulator add for the selected thruster.
  logic [IdxW-1:0] add_idx;
  logic [64:0] add_sum;
  assign add_idx = (state_q == StAdd1) ? pcur.first : pcur.second;
  assign add_sum = {33'd0, acc_q[add_idx]} + {1'b0, u_q};

  // Shared multiplier: matrix entry times accumulator, then the residual
  // squares and the tolerance square.
  logic signed [32:0] mul_a, mul_b;
  logic signed [65:0] mul_p;
  logic signed [71:0] dres;
  logic [71:0] dabs;
  logic [63:0] sq;
  logic [64:0] sq_sum;
  logic [31:0] dsel;
  assign dsel = dm_q[pk_q[1:0]];

  always_comb begin
    if (state_q == StSquare) begin
      mul_a = (pk_q == 3'd3) ? {1'b0, tol_q} : {1'b0, dsel};
      mul_b = mul_a;
    end else begin
      mul_a = 33'(rd_data_q);
      mul_b = {1'b0, acc_q[rix_q]};
    end
  end

  assign mul_p  = mul_a * mul_b;
  assign dres   = eff_q - {{24{tau_cur[31]}}, tau_cur, 16'd0};
  assign dabs   = dres[71] ? 72'(-dres) : dres;
  assign sq     = mul_p[63:0];
  assign sq_sum = {1'b0, sum_q} + {1'b0, sq};

  logic in_fire, out_fire;
  assign in_fire  = in_valid_i && !in_stall_o;
  assign out_fire = out_valid_o && !out_stall_i;
  assign in_stall_o = (state_q != StIdle);
  assign load_we = in_fire && op_e'(op_i) == OpLoad;

  // Next state and datapath updates.
  always_comb begin
    state_d = state_q;
    pk_d = pk_q; ix_d = ix_q; rv_d = 1'b0; rix_d = rix_q;
    m1_d = m1_q; m2_d = m2_q; b1_d = b1_q; b2_d = b2_q; pc_d = pc_q;
    ready_d = ready_q; u_d = u_q; eff_d = eff_q; sum_d = sum_q;
    okf_d = okf_q; oi_d = oi_q;
    pair_we = 1'b0; pair_wr = '0;
    acc_we = 1'b0; acc_waddr = '0; acc_wdata = '0;
    dm_we = 1'b0; dm_wdata = '0;
    div_start = 1'b0;
    rd_addr = ix_q[IdxW-1:0];
    rd_axis = pk_q[2:1];
    unique case (state_q)
      StIdle: begin
        if (in_fire) begin
          unique case (op_e'(op_i))
            OpBuild: begin
              state_d = StBuild; pk_d = '0; ix_d = '0;
              pc_d = '0; m1_d = '0; m2_d = '0; b1_d = '0; b2_d = '0;
              ready_d = 1'b1;
            end
            OpCommand: begin
              state_d = StClear; ix_d = '0; okf_d = ready_q;
            end
            default: ;
          endcase
        end
      end
      StBuild: begin
        // Issue a read while columns remain, fold in the previous read.
        if (ix_q < ncols) begin
          rv_d = 1'b1; rix_d = ix_q[IdxW-1:0]; ix_d = ix_q + 5'd1;
        end
        if (rv_q && cand) begin
          if (pc_q == 2'd0 || cmag > m1_q) begin
            m2_d = m1_q; b2_d = b1_q; m1_d = cmag; b1_d = rix_q;
          end else if (pc_q == 2'd1 || cmag > m2_q) begin
            m2_d = cmag; b2_d = rix_q;
          end
          if (pc_q != 2'd2) pc_d = pc_q + 2'd1;
        end
        if (ix_q >= ncols && !rv_q) begin
          pair_we = 1'b1;
          pair_wr.valid  = (pc_q == 2'd2);
          pair_wr.first  = (pc_q == 2'd2) ? b1_q : '0;
          pair_wr.second = (pc_q == 2'd2) ? b2_q : '0;
          pair_wr.gain   = (pc_q == 2'd2) ? m1_q + m2_q : '0;
          if (pc_q != 2'd2) ready_d = 1'b0;
          ix_d = '0; pc_d = '0; m1_d = '0; m2_d = '0; b1_d = '0; b2_d = '0;
          if (pk_q == 3'd5) state_d = StBuildOut;
          else pk_d = pk_q + 3'd1;
        end
      end
      StBuildOut: if (out_fire) state_d = StIdle;
      StClear: begin
        acc_we = 1'b1; acc_waddr = ix_q[IdxW-1:0];
        ix_d = ix_q + 5'd1;
        if (ix_q == 5'(MaxThrusters - 1)) begin
          pk_d = '0;
          state_d = okf_q ? StAxis : StFail;
        end
      end
      StAxis: begin
        if (pk_q == 3'd3) begin
          pk_d = '0; ix_d = '0; eff_d = '0; sum_d = '0;
          state_d = StResid;
        end else if (tau_mag < tol_q) begin
          pk_d = pk_q + 3'd1;
        end else if (!pcur.valid || pcur.gain == 32'd0) begin
          state_d = StFail;
        end else begin
          div_start = 1'b1; state_d = StDiv;
        end
      end
      StDiv: if (div_done) begin u_d = div_quot; state_d = StAdd1; end
      StAdd1, StAdd2: begin
        acc_we = 1'b1; acc_waddr = add_idx;
        acc_wdata = add_sum[64:32] != 33'd0 ? 32'hFFFF_FFFF : add_sum[31:0];
        if (state_q == StAdd1) state_d = StAdd2;
        else begin pk_d = pk_q + 3'd1; state_d = StAxis; end
      end
      StResid: begin
        rd_axis = pk_q[1:0];
        if (ix_q < ncols) begin
          rv_d = 1'b1; rix_d = ix_q[IdxW-1:0]; ix_d = ix_q + 5'd1;
        end
        if (rv_q) eff_d = eff_q + 72'(mul_p);
        if (ix_q >= ncols && !rv_q) state_d = StResidEnd;
      end
      StResidEnd: begin
        if (dabs[71:48] != 24'd0 || dabs[47:16] > tol_q) begin
          state_d = StFail;
        end else begin
          dm_we = 1'b1; dm_wdata = dabs[47:16];
          ix_d = '0; eff_d = '0;
          if (pk_q == 3'd2) begin pk_d = '0; state_d = StSquare; end
          else begin pk_d = pk_q + 3'd1; state_d = StResid; end
        end
      end
      StSquare: begin
        // Three residual squares are summed, then the tolerance is squared.
        if (pk_q == 3'd3) begin
          state_d = StOut; oi_d = '0;
          okf_d = (sum_q <= sq);
        end else begin
          sum_d = sq_sum[64] ? 64'hFFFF_FFFF_FFFF_FFFF : sq_sum[63:0];
          pk_d = pk_q + 3'd1;
        end
      end
      StFail: begin okf_d = 1'b0; oi_d = '0; state_d = StOut; end
      StOut: begin
        if (out_fire) begin
          oi_d = oi_q + 5'd1;
          if (oi_q + 5'd1 == ncols) state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  // Output drive.
  always_comb begin
    out_valid_o = 1'b0;
    thruster_number_o = '0;
    thruster_force_o = '0;
    ok_o = 1'b0;
    map_ready_o = ready_q;
    last_o = 1'b0;
    unique case (state_q)
      StBuildOut: begin out_valid_o = 1'b1; last_o = 1'b1; end
      StOut: begin
        out_valid_o = 1'b1;
        thruster_number_o = oi_q[3:0];
        thruster_force_o = okf_q ? acc_q[oi_q[IdxW-1:0]] : 32'd0;
        ok_o = okf_q;
        last_o = (oi_q + 5'd1 == ncols);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      pk_q <= '0; ix_q <= '0; rv_q <= 1'b0; pc_q <= '0;
      ready_q <= 1'b0; okf_q <= 1'b0; oi_q <= '0;
      for (int i = 0; i < 6; i++) pairs_q[i] <= '0;
      for (int i = 0; i < MaxThrusters; i++) acc_q[i] <= '0;
    end else begin
      state_q <= state_d;
      pk_q <= pk_d; ix_q <= ix_d; rv_q <= rv_d; pc_q <= pc_d;
      ready_q <= ready_d; okf_q <= okf_d; oi_q <= oi_d;
      if (pair_we) pairs_q[pk_q] <= pair_wr;
      if (acc_we) acc_q[acc_waddr] <= acc_wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    rix_q <= rix_d;
    m1_q <= m1_d; m2_q <= m2_d; b1_q <= b1_d; b2_q <= b2_d;
    u_q <= u_d; eff_q <= eff_d; sum_q <= sum_d;
    if (dm_we) dm_q[pk_q[1:0]] <= dm_wdata;
    if (in_fire && op_e'(op_i) == OpCommand) begin
      tau_q[0] <= torque_x_i;
      tau_q[1] <= torque_y_i;
      tau_q[2] <= torque_z_i;
    end
  end

`ifndef ASSERT_OFF
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != StIdle) |-> !in_fire) else $error("item accepted while busy");
  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !ok_o) |-> (thruster_force_o == 32'd0))
    else $error("failed command drives force");
  a_build_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StBuildOut) |-> (last_o && out_valid_o))
    else $error("build status without last");
  a_ready_map: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ready_q && state_q == StIdle) |-> (pairs_q[0].valid && pairs_q[5].valid))
    else $error("ready with invalid pair");
`endif

endmodule
